[hw/rtl/twmd_pkg.sv]
// Shared types and constants for the throttle window max-rise detector.
package twmd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 14;
  localparam int RISE_W     = 15;
  localparam int WIN_CFG_W  = 6;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL  = 2'd2;

  // Window length after reset, and samples needed to form a pair
  localparam int RESET_WINDOW = 4;
  localparam int MIN_PAIR     = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Per-beat command handed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                too_short;
  } cmd_t;

endpackage

[hw/rtl/twmd_if.sv]
// Valid/ready channel interfaces for samples in and results out.
interface twmd_in_if;
  import twmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] throttle_sample;

  modport source (output valid, output throttle_sample, input ready);
  modport sink (input valid, input throttle_sample, output ready);
endinterface

interface twmd_out_if;
  import twmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] from_value;
  logic [SAMPLE_W-1:0] to_value;
  logic [RISE_W-1:0]   rise;
  logic                accel_flag;
  logic                decel_flag;
  logic                too_short;

  modport source (output valid, output from_value, output to_value, output rise,
                  output accel_flag, output decel_flag, output too_short, input ready);
  modport sink (input valid, input from_value, input to_value, input rise,
                input accel_flag, input decel_flag, input too_short, output ready);
endinterface

[hw/rtl/twmd_queue.sv]
// Short FIFO that decouples the front end from the scan back end.
module twmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] dout
);
  import twmd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = entry[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/twmd_front.sv]
// Front end: config registers, ring pointer and fill count, command issue.
module twmd_front #(
  parameter int MAX_WINDOW = 32,
  parameter int PTR_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [twmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twmd_pkg::CFG_DATA_W-1:0] cfg_data,
  twmd_in_if.sink                      samples,
  input  logic                         q_full,
  output logic                         q_push,
  output twmd_pkg::cmd_t               cmd,
  output logic [PTR_W-1:0]             slot,
  output logic [CNT_W-1:0]             len,
  output logic [CNT_W-1:0]             window,
  output logic [twmd_pkg::SAMPLE_W-1:0] accel_threshold,
  output logic [twmd_pkg::SAMPLE_W-1:0] decel_threshold
);
  import twmd_pkg::*;

  localparam int RESET_WIN = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

  logic [PTR_W-1:0]     wr_ptr;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     wr_inc;
  logic [CNT_W-1:0]     fill_next;
  logic [WIN_CFG_W-1:0] win_cfg;

  assign samples.ready = !q_full;
  assign q_push        = samples.valid && !q_full;

  // Next pointer and fill count for the beat being taken
  always_comb begin
    wr_inc    = CNT_W'(wr_ptr) + CNT_W'(1);
    fill_next = (fill < window) ? fill + CNT_W'(1) : fill;
  end

  assign slot          = wr_ptr;
  assign len           = fill_next;
  assign cmd.sample    = samples.throttle_sample;
  assign cmd.too_short = (fill_next < CNT_W'(MIN_PAIR));
  assign win_cfg       = cfg_data[WIN_CFG_W-1:0];

  // Config writes and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      window          <= CNT_W'(RESET_WIN);
      accel_threshold <= '0;
      decel_threshold <= '0;
      wr_ptr          <= '0;
      fill            <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: begin
          if (win_cfg != '0) begin
            if (int'(win_cfg) > MAX_WINDOW) begin
              window <= CNT_W'(MAX_WINDOW);
            end else begin
              window <= CNT_W'(win_cfg);
            end
            wr_ptr <= '0;
            fill   <= '0;
          end
        end
        REG_ACCEL: accel_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_DECEL: decel_threshold <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end else if (q_push) begin
      wr_ptr <= (wr_inc >= window) ? '0 : wr_inc[PTR_W-1:0];
      fill   <= fill_next;
    end
  end

endmodule

[hw/rtl/twmd_back.sv]
// Back end: ring memory write, pairwise scan for largest rise, result register.
module twmd_back #(
  parameter int MAX_WINDOW = 32,
  parameter int PTR_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  twmd_pkg::cmd_t                cmd,
  input  logic [PTR_W-1:0]              slot,
  input  logic [CNT_W-1:0]              len,
  input  logic [CNT_W-1:0]              window,
  input  logic [twmd_pkg::SAMPLE_W-1:0] accel_threshold,
  input  logic [twmd_pkg::SAMPLE_W-1:0] decel_threshold,
  twmd_out_if.source                    results
);
  import twmd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]                state;
  cmd_t                      cur;
  logic [PTR_W-1:0]          cur_slot;
  logic [CNT_W-1:0]          cur_len;
  logic [CNT_W-1:0]          pairs_left;
  logic [PTR_W-1:0]          rd_addr;
  logic [PTR_W-1:0]          rd_addr_next;
  logic [SAMPLE_W-1:0]       rd_data;
  logic [SAMPLE_W-1:0]       prev;
  logic signed [RISE_W-1:0]  best;
  logic signed [RISE_W-1:0]  diff;
  logic [SAMPLE_W-1:0]       best_from;
  logic [SAMPLE_W-1:0]       best_to;
  logic signed [RISE_W-1:0]  fin_rise;
  logic signed [RISE_W-1:0]  accel_s;
  logic signed [RISE_W-1:0]  decel_neg;
  logic                      out_free;
  logic [SAMPLE_W-1:0]       ring [MAX_WINDOW];

  // Step one slot back, wrapping inside the window
  function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] last;
    last = w - CNT_W'(1);
    return (a == '0) ? last[PTR_W-1:0] : a - PTR_W'(1);
  endfunction

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !results.valid || results.ready;

  // Read address: first older neighbor on write, then walk back during scan
  always_comb begin
    case (state)
      S_WRITE: rd_addr_next = step_back(cur_slot, window);
      S_SCAN:  rd_addr_next = step_back(rd_addr, window);
      default: rd_addr_next = rd_addr;
    endcase
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      ring[cur_slot] <= cur.sample;
    end
    rd_data <= ring[rd_addr_next];
  end

  // Rise of the pair (prev newer, rd_data older)
  assign diff = $signed({1'b0, prev}) - $signed({1'b0, rd_data});

  // Result arithmetic
  assign fin_rise  = $signed({1'b0, best_to}) - $signed({1'b0, best_from});
  assign accel_s   = $signed({1'b0, accel_threshold});
  assign decel_neg = -$signed({1'b0, decel_threshold});

  // Sequencer and scan datapath
  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur      <= cmd;
          cur_slot <= slot;
          cur_len  <= len;
        end
      end
      S_WRITE: begin
        prev       <= cur.sample;
        best       <= {1'b1, {(RISE_W-1){1'b0}}};
        pairs_left <= cur_len - CNT_W'(1);
        best_to    <= cur.sample;
        best_from  <= (window == CNT_W'(1)) ? cur.sample : '0;
      end
      S_SCAN: begin
        // strict compare keeps the newest pair on ties
        if (diff > best) begin
          best      <= diff;
          best_to   <= prev;
          best_from <= rd_data;
        end
        prev       <= rd_data;
        pairs_left <= pairs_left - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (q_valid) state <= S_WRITE;
        S_WRITE: state <= cur.too_short ? S_FIN : S_SCAN;
        S_SCAN:  if (pairs_left == CNT_W'(1)) state <= S_FIN;
        S_FIN:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      results.from_value <= best_from;
      results.to_value   <= best_to;
      results.rise       <= fin_rise;
      results.accel_flag <= (fin_rise > accel_s);
      results.decel_flag <= (fin_rise < decel_neg);
      results.too_short  <= cur.too_short;
    end
  end

endmodule

[hw/rtl/throttle_window_max_delta_detector.sv]
// Top level of the throttle window max-rise detector.
// Each throttle sample is stored in a ring of window_length slots and the
// block returns the consecutive pair with the largest rise among the last
// min(window_length, samples seen) samples, newest pair winning ties, with
// accel/decel flags. The front end takes a sample beat whenever the 2-deep
// command queue has room; the back end then works on one sample at a time,
// stepping through its write, scan and finish states, where the scan walks
// back over the samples held in the window (it is skipped when fewer than
// two are held) and reads one older ring entry per cycle through the single
// read port of the sample memory. A finished result sits
// in the output register while the next sample is being worked on. The ring
// is not cleared after reset or a window write; the fill count keeps every
// scan on entries written since.
module throttle_window_max_delta_detector #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [twmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twmd_pkg::CFG_DATA_W-1:0] cfg_data,
  twmd_in_if.sink                         samples,
  twmd_out_if.source                      results
);
  import twmd_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int Q_W   = $bits(cmd_t) + PTR_W + CNT_W;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_valid;
  cmd_t                f_cmd;
  cmd_t                b_cmd;
  logic [PTR_W-1:0]    f_slot;
  logic [PTR_W-1:0]    b_slot;
  logic [CNT_W-1:0]    f_len;
  logic [CNT_W-1:0]    b_len;
  logic [CNT_W-1:0]    window;
  logic [SAMPLE_W-1:0] accel_threshold;
  logic [SAMPLE_W-1:0] decel_threshold;
  logic [Q_W-1:0]      q_din;
  logic [Q_W-1:0]      q_dout;

  twmd_front #(
    .MAX_WINDOW(MAX_WINDOW),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .samples        (samples),
    .q_full         (q_full),
    .q_push         (q_push),
    .cmd            (f_cmd),
    .slot           (f_slot),
    .len            (f_len),
    .window         (window),
    .accel_threshold(accel_threshold),
    .decel_threshold(decel_threshold)
  );

  assign q_din = {f_cmd, f_slot, f_len};

  twmd_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .din      (q_din),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .dout     (q_dout)
  );

  assign {b_cmd, b_slot, b_len} = q_dout;

  twmd_back #(
    .MAX_WINDOW(MAX_WINDOW),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .cmd            (b_cmd),
    .slot           (b_slot),
    .len            (b_len),
    .window         (window),
    .accel_threshold(accel_threshold),
    .decel_threshold(decel_threshold),
    .results        (results)
  );

  // Rise always equals the difference of the reported pair
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.rise == (RISE_W'(results.to_value) - RISE_W'(results.from_value)))
    else $error("rise does not match reported pair");

  // Thresholds are non-negative, so both flags can never be set together
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.accel_flag && results.decel_flag))
    else $error("accel and decel flags both set");

  // A short window pairs the sample with zero or with itself
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.too_short |-> results.from_value == '0 || results.rise == '0)
    else $error("short window pair is not cleared slot or self");

  // Queue is only popped while it holds a command
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && !$past(q_pop && !q_push && !q_valid))
    else $error("command queue popped while empty");

endmodule

[verif/twmd_rise_checker.sv]
// Scoreboard for the throttle window max-rise detector: predicts and checks results.
module twmd_rise_checker
  import twmd_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  twmd_in_if                    samples,
  twmd_out_if                   results,
  output int                    pending,
  output int                    mismatch_count
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] from_v;
    logic [SAMPLE_W-1:0] to_v;
    logic [RISE_W-1:0]   rise;
    logic                accel;
    logic                decel;
    logic                short_win;
  } rise_pair_t;

  // Shadow copy of the block state and registers
  logic [SAMPLE_W-1:0]   ring_q [MAX_WINDOW];
  int                    wr_ptr;
  int                    fill;
  int                    win_len;
  logic [CFG_DATA_W-1:0] accel_thr;
  logic [CFG_DATA_W-1:0] decel_thr;

  rise_pair_t rise_pair_q [$];
  rise_pair_t want;

  initial begin
    pending = 0;
    mismatch_count = 0;
  end

  function automatic void clear_ring();
    for (int i = 0; i < MAX_WINDOW; i++) ring_q[i] = '0;
    wr_ptr = 0;
    fill = 0;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int wl;
    wl = int'(data[WIN_CFG_W-1:0]);
    case (idx)
      REG_WINDOW: begin
        // zero is dropped without touching the ring
        if (wl != 0) begin
          win_len = (wl > MAX_WINDOW) ? MAX_WINDOW : wl;
          clear_ring();
        end
      end
      REG_ACCEL: accel_thr = data;
      REG_DECEL: decel_thr = data;
      default: ;
    endcase
  endfunction

  // Ring entry at a signed position, wrapped into the window
  function automatic logic [SAMPLE_W-1:0] ring_at(int pos);
    int p;
    p = pos % win_len;
    if (p < 0) p += win_len;
    return ring_q[p];
  endfunction

  // Store one sample and find the newest pair with the largest rise
  function automatic rise_pair_t store_and_scan(logic [SAMPLE_W-1:0] s);
    rise_pair_t r;
    int len;
    int newest;
    int pick;
    int best;
    int d;
    int rise_i;
    int i;
    if (wr_ptr >= win_len) wr_ptr = 0;
    ring_q[wr_ptr] = s;
    wr_ptr++;
    if (wr_ptr >= win_len) wr_ptr = 0;
    if (fill < win_len) fill++;
    len = (fill < win_len) ? fill : win_len;
    r.short_win = (len < MIN_PAIR);
    pick = 0;
    if (!r.short_win) begin
      newest = wr_ptr - 1;
      pick = newest;
      best = int'(ring_at(newest)) - int'(ring_at(newest - 1));
      for (i = 1; i < len - 1; i++) begin
        d = int'(ring_at(newest - i)) - int'(ring_at(newest - i - 1));
        if (d > best) begin
          best = d;
          pick = newest - i;
        end
      end
    end
    // with under two samples slot 0 pairs with the cleared last slot or itself
    r.to_v = ring_at(pick);
    r.from_v = ring_at(pick - 1);
    rise_i = int'(r.to_v) - int'(r.from_v);
    r.rise = rise_i[RISE_W-1:0];
    r.accel = (rise_i > int'(accel_thr));
    r.decel = (rise_i < -int'(decel_thr));
    return r;
  endfunction

  task automatic report(string field, int got, int exp_val);
    mismatch_count++;
    $display("mismatch on %s: got %0d, want %0d", field, got, exp_val);
  endtask

  // Track config writes, predict on each sample beat, compare each result beat
  always @(posedge clk) begin
    if (rst) begin
      win_len = RESET_WINDOW;
      accel_thr = '0;
      decel_thr = '0;
      clear_ring();
      rise_pair_q.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (samples.valid && samples.ready)
        rise_pair_q.push_back(store_and_scan(samples.throttle_sample));
      if (results.valid && results.ready) begin
        if (rise_pair_q.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = rise_pair_q.pop_front();
          if (results.from_value !== want.from_v)
            report("from_value", int'(results.from_value), int'(want.from_v));
          if (results.to_value !== want.to_v)
            report("to_value", int'(results.to_value), int'(want.to_v));
          if (results.rise !== want.rise)
            report("rise", int'($signed(results.rise)), int'($signed(want.rise)));
          if (results.accel_flag !== want.accel)
            report("accel_flag", int'(results.accel_flag), int'(want.accel));
          if (results.decel_flag !== want.decel)
            report("decel_flag", int'(results.decel_flag), int'(want.decel));
          if (results.too_short !== want.short_win)
            report("too_short", int'(results.too_short), int'(want.short_win));
        end
      end
    end
    pending <= rise_pair_q.size();
  end

endmodule

[verif/testbench.sv]
// Top of the detector testbench: clock, reset, config writes, sample and stall stimulus.
module testbench;
  import twmd_pkg::*;

  localparam int MAX_WINDOW  = 32;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = MAX_WINDOW + 8;
  localparam int SAMPLE_TOP  = 10000;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_req;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    quiet;
  int                    pending;
  int                    mismatch_count;
  int                    last_throttle;

  twmd_in_if  in_ch ();
  twmd_out_if out_ch ();

  throttle_window_max_delta_detector #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(in_ch),
    .results(out_ch)
  );

  twmd_rise_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(in_ch),
    .results(out_ch),
    .pending(pending),
    .mismatch_count(mismatch_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Throttle-like profile: ramps, plateaus, jumps, and raw 14-bit values
  function automatic logic [SAMPLE_W-1:0] next_throttle();
    int k;
    int v;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      v = last_throttle + $urandom_range(0, 400) - 200;
      if (v < 0) v = 0;
      if (v > SAMPLE_TOP) v = SAMPLE_TOP;
    end else if (k < 70) begin
      v = last_throttle;
    end else if (k < 85) begin
      v = $urandom_range(0, SAMPLE_TOP);
    end else if (k < 93) begin
      v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
    end else begin
      v = $urandom_range(0, (1 << SAMPLE_W) - 1);
    end
    last_throttle = v;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.throttle_sample <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, let every result drain, then give the back end time to settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] acc,
                            input logic [CFG_DATA_W-1:0] dec);
    cfg_put(REG_WINDOW, win);
    cfg_put(REG_ACCEL, acc);
    cfg_put(REG_DECEL, dec);
    cfg_done();
  endtask

  task automatic send_list(input int vals[$]);
    foreach (vals[i]) send_sample(vals[i][SAMPLE_W-1:0]);
  endtask

  initial begin
    int ph;
    int n;
    logic [CFG_DATA_W-1:0] win;
    logic [CFG_DATA_W-1:0] acc;
    logic [CFG_DATA_W-1:0] dec;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet = 0;
    last_throttle = 0;
    in_ch.valid = 1'b0;
    in_ch.throttle_sample = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: first sample pairs with a cleared slot, full scale, ties
    send_list('{0, 10000, 0, 16383, 16383, 100, 200, 300});
    wait_idle();

    // One-slot window with thresholds at the top of the field
    write_regs(14'd1, 14'h3FFF, 14'h3FFF);
    send_list('{7, 9000});
    wait_idle();

    // Rise equal to the threshold, then a falling run for decel
    write_regs(14'd3, 14'd50, 14'd50);
    send_list('{100, 150, 300, 200, 100});
    wait_idle();

    // Window write of zero is dropped and keeps the ring; odd index does nothing
    cfg_put(REG_WINDOW, 14'h0040);
    cfg_put(REG_UNUSED, 14'h3FFF);
    cfg_done();
    send_sample(14'd50);
    wait_idle();

    // Oversized window saturates to the maximum
    write_regs(14'd40, 14'd0, 14'd10000);
    send_list('{10000, 0, 0});
    wait_idle();

    // Random phases over window and threshold settings and idle patterns
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 69;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 69;
        end
        default: begin
          send_idle_pct <= 25;
          recv_stall_pct <= 25;
        end
      endcase
      case (ph)
        0: win = 14'd32;
        1: win = 14'd1;
        2: win = 14'd2;
        3: win = 14'd63;
        7: win = $urandom_range(0, (1 << CFG_DATA_W) - 1);
        default: win = $urandom_range(1, MAX_WINDOW);
      endcase
      case (ph)
        2: begin
          acc = '0;
          dec = '0;
        end
        3: begin
          acc = '1;
          dec = '1;
        end
        5, 9: begin
          acc = $urandom_range(0, (1 << CFG_DATA_W) - 1);
          dec = $urandom_range(0, (1 << CFG_DATA_W) - 1);
        end
        default: begin
          acc = $urandom_range(0, 600);
          dec = $urandom_range(0, 600);
        end
      endcase
      write_regs(win, acc, dec);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long result hold-off while samples keep coming, to back up the input
        if (ph == 4 && n == 20) hold_req <= 1'b1;
        send_sample(next_throttle());
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
